@@ design/lsh_pkg.sv @@
// Shared constants, codes and line-store request types for the 3x3 Laplacian sharpener.
// No dependencies; every other design file imports this package.
`default_nettype none

package lsh_pkg;

  localparam int MAX_WIDTH   = 2048;                     // longest supported row
  localparam int PIX_W       = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);        // column index
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);    // effective row width
  localparam int PEND_W      = $clog2(MAX_WIDTH + 2);    // results held back, up to width+1
  localparam int ROW_W       = 16;
  localparam int FW_FIELD_W  = 12;                       // frame_width register
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_RST  = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  typedef enum logic {
    KERNEL_FOUR  = 1'b0,
    KERNEL_EIGHT = 1'b1
  } kernel_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr_u;
    logic [COL_W-1:0] addr_m;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] data_u;
    logic [PIX_W-1:0] data_m;
  } wr_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } rd_data_t;

endpackage

`default_nettype wire

@@ design/lsh_stream_if.sv @@
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on lsh_pkg for the pixel width.
`default_nettype none

interface lsh_in_if
  import lsh_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface lsh_out_if
  import lsh_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ design/lsh_line_store.sv @@
// Two row memories (upper and middle line) with registered reads and
// write-to-read forwarding for a write landing on the same edge. Uses lsh_pkg.
`default_nettype none

module lsh_line_store
  import lsh_pkg::*;
(
  input  logic     clk,
  input  rd_req_t  rd_req,
  input  wr_req_t  wr_req,
  output rd_data_t rd_data
);

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] upper_q_r;
  logic [PIX_W-1:0] middle_q_r;
  logic             fwd_u_r;
  logic             fwd_m_r;
  logic [PIX_W-1:0] fwd_u_data_r;
  logic [PIX_W-1:0] fwd_m_data_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      upper_mem[wr_req.addr] <= wr_req.data_u;
    end
    if (rd_req.en) begin
      upper_q_r <= upper_mem[rd_req.addr_u];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      middle_mem[wr_req.addr] <= wr_req.data_m;
    end
    if (rd_req.en) begin
      middle_q_r <= middle_mem[rd_req.addr_m];
    end
  end

  // Capture a write that hits the entry being read on the same edge.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      fwd_u_r      <= wr_req.en && (wr_req.addr == rd_req.addr_u);
      fwd_m_r      <= wr_req.en && (wr_req.addr == rd_req.addr_m);
      fwd_u_data_r <= wr_req.data_u;
      fwd_m_data_r <= wr_req.data_m;
    end
  end

  assign rd_data.upper  = fwd_u_r ? fwd_u_data_r : upper_q_r;
  assign rd_data.middle = fwd_m_r ? fwd_m_data_r : middle_q_r;

endmodule

`default_nettype wire

@@ design/laplacian_sharpen_3x3_core.sv @@
// Top level of the streaming 3x3 Laplacian sharpener.
// Depends on lsh_pkg, lsh_stream_if (lsh_in_if, lsh_out_if) and lsh_line_store.
`default_nettype none

// Gray pixels arrive in raster order on in_ch, one per beat; the block takes one beat per
// clock and gives at most one result beat per input beat. Each result belongs to the pixel
// frame_width+1 beats earlier, so the first row and one pixel produce nothing; after the
// frame's last pixel, send drain beats (req_type = 1) to flush the held-back results, the
// final one carrying last_of_frame. A drain beat sent before the frame is complete is
// dropped, and any beat sent once the frame is complete acts as a drain until the last
// result is out. Interior pixels become clamp(5p - N - S - E - W) with neighbor_mode 0 or
// clamp(9p - all eight neighbors) with neighbor_mode 1; border rows and columns pass
// through. Throughput is one beat per clock while out_ch takes results, set by the two
// line-store memories, each read and written once per clock; a write and a read of the
// same entry on one edge are forwarded. An accepted beat passes through the memory read,
// the window update, and the kernel and output register before its result beat. Two
// result stages give slack: the block keeps accepting while one result waits on out_ch.
// Writing frame_width or frame_height abandons the frame in progress; configure only
// while idle. Line stores need no clearing pass after reset.
module laplacian_sharpen_3x3_core
  import lsh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lsh_in_if.sink                in_ch,
  lsh_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = 12;  // holds 9 * 255 and the eight-neighbor sum

  typedef logic [8:0][PIX_W-1:0] win_t;  // index row*3+col, row 0 oldest, col 2 newest

  function automatic logic [WID_W-1:0] eff_width(input logic [FW_FIELD_W-1:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(MAX_WIDTH)) v = 32'(MAX_WIDTH);
    return WID_W'(v);
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] raw);
    return (raw == '0) ? ROW_W'(1) : raw;
  endfunction

  function automatic logic [PIX_W-1:0] sharpen(input logic mode, input win_t w);
    logic [SUM_W-1:0]      ctr;
    logic [SUM_W-1:0]      nsum;
    logic signed [SUM_W:0] diff;
    logic [PIX_W-1:0]      res;
    if (mode == KERNEL_EIGHT) begin
      ctr  = (SUM_W'(w[4]) << 3) + SUM_W'(w[4]);
      nsum = SUM_W'(w[0]) + SUM_W'(w[1]) + SUM_W'(w[2]) + SUM_W'(w[3])
           + SUM_W'(w[5]) + SUM_W'(w[6]) + SUM_W'(w[7]) + SUM_W'(w[8]);
    end else begin
      ctr  = (SUM_W'(w[4]) << 2) + SUM_W'(w[4]);
      nsum = SUM_W'(w[1]) + SUM_W'(w[3]) + SUM_W'(w[5]) + SUM_W'(w[7]);
    end
    diff = $signed({1'b0, ctr}) - $signed({1'b0, nsum});
    // Clamp: negative goes to zero, anything above the pixel range saturates.
    if (diff[SUM_W]) begin
      res = '0;
    end else if (|diff[SUM_W-1:PIX_W]) begin
      res = '1;
    end else begin
      res = diff[PIX_W-1:0];
    end
    return res;
  endfunction

  // Configuration, kept in effective form.
  logic             mode_r,  mode_nxt;
  logic [WID_W-1:0] eff_w_r, eff_w_nxt;
  logic [ROW_W-1:0] eff_h_r, eff_h_nxt;
  logic             geom_wr;

  // Frame position.
  logic [COL_W-1:0]  col_r,     col_nxt;
  logic [ROW_W-1:0]  row_r,     row_nxt;
  logic [PEND_W-1:0] pending_r, pending_nxt;

  // Accept-side decode.
  logic              in_ready;
  logic              in_acc;
  logic              frame_done;
  logic              drain_hit;
  logic              pix_item;
  logic              have_out;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [WID_W-1:0]  col_inc;

  // Stage 1: memory data back.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_pix_r;
  logic              s1_out_r;
  logic              s1_interior_r;
  logic              s1_last_r;
  logic              s1_sel_up_r;
  logic [COL_W-1:0]  s1_addr_r;
  logic [PIX_W-1:0]  s1_data_r;

  // Stage 2: window holds the neighborhood, kernel runs.
  logic              s2_valid_r, s2_valid_nxt;
  logic              s2_drain_r;
  logic              s2_interior_r;
  logic              s2_last_r;
  logic [PIX_W-1:0]  s2_dval_r;
  logic [PIX_W-1:0]  s2_value;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  logic              out_free;
  logic              s2_free;
  logic              s1_free;
  logic              s1_adv;

  win_t              window_r;
  win_t              window_nxt;

  rd_req_t           rd_req;
  wr_req_t           wr_req;
  rd_data_t          rd_data;

  lsh_line_store u_store (
    .clk     (clk),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------- configuration
  always_comb begin
    mode_nxt  = mode_r;
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    geom_wr   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: begin
          mode_nxt = cfg_data[0];
        end
        CFG_WIDTH: begin
          eff_w_nxt = eff_width(cfg_data[FW_FIELD_W-1:0]);
          geom_wr   = 1'b1;
        end
        CFG_HEIGHT: begin
          eff_h_nxt = eff_height(cfg_data[ROW_W-1:0]);
          geom_wr   = 1'b1;
        end
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    s2_free  = !s2_valid_r || out_free;
    s1_free  = !s1_valid_r || s2_free;
    s1_adv   = s1_valid_r && s2_free;
    in_ready = s1_free;
    in_acc   = in_ch.valid && in_ready;
  end

  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------- accept decode
  always_comb begin
    frame_done = row_r >= eff_h_r;
    drain_hit  = frame_done && (pending_r != '0);
    pix_item   = !drain_hit && (in_ch.req_type == REQ_PIXEL);
    have_out   = pending_r > PEND_W'(eff_w_r);
    if (frame_done || (WID_W'(col_r) >= eff_w_r)) begin
      col_cur = '0;
    end else begin
      col_cur = col_r;
    end
    row_cur = frame_done ? '0 : row_r;
    col_inc = WID_W'(col_cur) + WID_W'(1);
  end

  // Frame counters: advance on accepted beats, restart on a geometry write.
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pending_nxt = pending_r;
    if (geom_wr) begin
      col_nxt     = '0;
      row_nxt     = '0;
      pending_nxt = '0;
    end else if (in_acc) begin
      if (drain_hit) begin
        pending_nxt = pending_r - PEND_W'(1);
        if (pending_r == PEND_W'(1)) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end else begin
        col_nxt = col_cur;
        row_nxt = row_cur;
        if (pix_item) begin
          if (!have_out) begin
            pending_nxt = pending_r + PEND_W'(1);
          end
          if (col_inc >= eff_w_r) begin
            col_nxt = '0;
            row_nxt = row_cur + ROW_W'(1);
          end else begin
            col_nxt = COL_W'(col_inc);
          end
        end
      end
    end
  end

  // Memory reads: a pixel reads its column in both lines; a drain reads the held result.
  always_comb begin
    rd_req.en = in_acc && (drain_hit || pix_item);
    if (drain_hit) begin
      rd_req.addr_u = COL_W'(eff_w_r - WID_W'(1));
      rd_req.addr_m = COL_W'(PEND_W'(eff_w_r) - pending_r);
    end else begin
      rd_req.addr_u = col_cur;
      rd_req.addr_m = col_cur;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = rd_req.en;
    end
  end

  // Shift the lines down: middle moves to upper, the new pixel becomes middle.
  always_comb begin
    wr_req.en     = s1_adv && s1_pix_r;
    wr_req.addr   = s1_addr_r;
    wr_req.data_u = rd_data.middle;
    wr_req.data_m = s1_data_r;
  end

  always_comb begin
    window_nxt = window_r;
    for (int k = 0; k < 3; k++) begin
      window_nxt[k*3]     = window_r[k*3 + 1];
      window_nxt[k*3 + 1] = window_r[k*3 + 2];
    end
    window_nxt[2] = rd_data.upper;
    window_nxt[5] = rd_data.middle;
    window_nxt[8] = s1_data_r;
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r && s1_out_r;
    end
  end

  always_comb begin
    if (s2_drain_r) begin
      s2_value = s2_dval_r;
    end else if (s2_interior_r) begin
      s2_value = sharpen(mode_r, window_r);
    end else begin
      s2_value = window_r[4];
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_out     = out_pix_r;
  assign out_ch.last_of_frame = out_last_r;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= KERNEL_FOUR;
      eff_w_r     <= eff_width(FW_FIELD_W'(WIDTH_RST));
      eff_h_r     <= eff_height(ROW_W'(HEIGHT_RST));
      col_r       <= '0;
      row_r       <= '0;
      pending_r   <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      mode_r      <= mode_nxt;
      eff_w_r     <= eff_w_nxt;
      eff_h_r     <= eff_h_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pending_r   <= pending_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_req.en) begin
        window_r <= window_nxt;
      end
    end
  end

  // Payload: load on the beat that fills the stage, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r      <= pix_item;
      s1_out_r      <= drain_hit || have_out;
      s1_interior_r <= (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
      s1_last_r     <= drain_hit && (pending_r == PEND_W'(1));
      s1_sel_up_r   <= have_out;
      s1_addr_r     <= col_cur;
      s1_data_r     <= in_ch.pixel_in;
    end
    if (s1_adv) begin
      s2_drain_r    <= !s1_pix_r;
      s2_interior_r <= s1_interior_r;
      s2_last_r     <= s1_last_r;
      s2_dval_r     <= s1_sel_up_r ? rd_data.upper : rd_data.middle;
    end
    if (out_free && s2_valid_r) begin
      out_pix_r  <= s2_value;
      out_last_r <= s2_last_r;
    end
  end

`ifndef SYNTH
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(eff_w_r) + PEND_W'(1))
    else $error("held-back result count exceeds row width plus one");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WID_W'(col_r) < eff_w_r)
    else $error("column counter outside the row");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_addr_r) && $stable(window_r))
    else $error("stage 1 or window moved while stage 2 was blocked");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s2_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
